### rtl/core/brush_dab_coverage_top_defines.svh
// ---------------------------------------------------------------------------
// brush_dab_coverage_top_defines - assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ---------------------------------------------------------------------------
`ifndef BRUSH_DAB_COVERAGE_TOP_DEFINES_SVH
`define BRUSH_DAB_COVERAGE_TOP_DEFINES_SVH

// same-cycle implication
`define BDC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BDC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// fixed-delay implication
`define BDC_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

### rtl/core/bdc_pkg.sv
// ---------------------------------------------------------------------------
// bdc_pkg - shared types and constants for the brush dab coverage pipeline
// Fixed-point widths, stage counts and derived configuration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdc_pkg;

	localparam int COVER_FRAC_BITS = 16;
	localparam int COV_W = COVER_FRAC_BITS + 1;

	localparam int PIX_W = 16;
	localparam int CTR_W = 24;
	localparam int RAD_W = 20;
	localparam int EDGE_W = 16;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 2;
	localparam int SUB_W = 8;

	localparam int OFS_W = 26;
	localparam int ABS_W = 25;
	localparam int SQ_W = 2 * ABS_W + 1;

	localparam int SQRT_IN_W = 60;
	localparam int ROOT_W = SQRT_IN_W / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int SQRT_STEPS = 2;
	localparam int SQRT_STAGES = SQRT_IN_W / (2 * SQRT_STEPS);

	localparam int NUM_W = RAD_W + 4;
	localparam int DOT_NUM_W = 13;
	localparam int DOT_R_W = 9;
	localparam int DOT_P_W = DOT_NUM_W + DOT_R_W;
	localparam int DOT_SHIFT = 20;
	localparam int DIV_STEPS = 2;
	localparam int DIV_STAGES = (COVER_FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;

	localparam int LATENCY = 3 + SQRT_STAGES + 2 + DIV_STAGES + 1;

	localparam logic [SUB_W-1:0] PIX_HALF = 8'h80;
	localparam logic [RAD_W-1:0] ONE_Q8 = 20'd256;
	localparam logic [ROOT_W-1:0] ONE_Q12 = 30'd4096;
	localparam logic [COV_W-1:0] COV_FULL = {1'b1, {COVER_FRAC_BITS{1'b0}}};

	localparam logic [RAD_W-1:0] RADIUS_RST = 20'd256;
	localparam logic [EDGE_W-1:0] EDGE_RST = 16'd256;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X,
		REG_CENTER_Y,
		REG_DAB_RADIUS,
		REG_EDGE_WIDTH
	} bdc_reg_t;

	typedef struct packed {
		logic dot_case;
		logic [NUM_W-1:0] r12;
		logic [NUM_W-1:0] den12;
		logic [DOT_R_W-1:0] r_dot;
	} bdc_cfg_t;

	function automatic bdc_cfg_t derive_cfg(input logic [RAD_W-1:0] r,
		input logic [EDGE_W-1:0] e);
		bdc_cfg_t c;
		logic [RAD_W-1:0] lim;
		logic [RAD_W-1:0] den;
		lim = ONE_Q8 + RAD_W'(e);
		den = (r <= lim) ? r : RAD_W'(e);
		c.dot_case = (r <= ONE_Q8);
		c.r12 = {r, 4'b0000};
		c.den12 = {den, 4'b0000};
		c.r_dot = r[DOT_R_W-1:0];
		return c;
	endfunction

endpackage

### rtl/core/bdc_dist.sv
// ---------------------------------------------------------------------------
// bdc_dist - squared distance pipeline
// Offset to the dab centre, absolute value, squares and their sum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdc_dist import bdc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic signed [PIX_W-1:0] pixel_x,
	input  logic signed [PIX_W-1:0] pixel_y,
	input  logic signed [CTR_W-1:0] center_x,
	input  logic signed [CTR_W-1:0] center_y,
	output logic                    sq_vld,
	output logic [SQ_W-1:0]         sq,
	output logic                    active
);

	logic [OFS_W-1:0] dx;
	logic [OFS_W-1:0] dy;
	logic [ABS_W-1:0] ax;
	logic [ABS_W-1:0] ay;

	logic vld_s1, vld_s2, vld_s3;
	logic [ABS_W-1:0] ax_s1, ay_s1;
	logic [2*ABS_W-1:0] sqx_s2, sqy_s2;
	logic [SQ_W-1:0] sq_s3;

	// pixel centre (Q.8) minus dab centre
	always_comb begin
		dx = {{(OFS_W-PIX_W-SUB_W){pixel_x[PIX_W-1]}}, pixel_x, PIX_HALF}
			- {{(OFS_W-CTR_W){center_x[CTR_W-1]}}, center_x};
		dy = {{(OFS_W-PIX_W-SUB_W){pixel_y[PIX_W-1]}}, pixel_y, PIX_HALF}
			- {{(OFS_W-CTR_W){center_y[CTR_W-1]}}, center_y};
		ax = dx[OFS_W-1] ? ABS_W'(~dx + OFS_W'(1)) : ABS_W'(dx);
		ay = dy[OFS_W-1] ? ABS_W'(~dy + OFS_W'(1)) : ABS_W'(dy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		sqx_s2 <= (2*ABS_W)'(ax_s1) * (2*ABS_W)'(ax_s1);
		sqy_s2 <= (2*ABS_W)'(ay_s1) * (2*ABS_W)'(ay_s1);
		sq_s3 <= SQ_W'(sqx_s2) + SQ_W'(sqy_s2);
	end

	assign sq_vld = vld_s3;
	assign sq = sq_s3;
	assign active = vld_s1 | vld_s2 | vld_s3;

endmodule

### rtl/core/bdc_sqrt.sv
// ---------------------------------------------------------------------------
// bdc_sqrt - pipelined integer square root
// Digit-by-digit root of the Q.16 squared distance, widened to Q.24, two root bits per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdc_sqrt import bdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [SQ_W-1:0]   sq,
	output logic              root_vld,
	output logic [ROOT_W-1:0] root,
	output logic              active
);

	logic vld_s [SQRT_STAGES];
	logic [SQRT_IN_W-1:0] rad_s [SQRT_STAGES];
	logic [REM_W-1:0] rem_s [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];

	logic [SQRT_IN_W-1:0] rad_n [SQRT_STAGES];
	logic [REM_W-1:0] rem_n [SQRT_STAGES];
	logic [ROOT_W-1:0] root_n [SQRT_STAGES];

	always_comb begin
		logic [SQRT_IN_W-1:0] rad_c;
		logic [REM_W-1:0] rem_c;
		logic [ROOT_W-1:0] root_c;
		logic [REM_W+1:0] acc_c;
		logic [REM_W+1:0] trial_c;
		for (int g = 0; g < SQRT_STAGES; g++) begin
			if (g == 0) begin
				rad_c = {{(SQRT_IN_W-SQ_W-SUB_W){1'b0}}, sq, {SUB_W{1'b0}}};
				rem_c = '0;
				root_c = '0;
			end else begin
				rad_c = rad_s[g-1];
				rem_c = rem_s[g-1];
				root_c = root_s[g-1];
			end
			for (int k = 0; k < SQRT_STEPS; k++) begin
				acc_c = {rem_c, rad_c[SQRT_IN_W-1 -: 2]};
				trial_c = (REM_W+2)'({root_c, 2'b01});
				rad_c = {rad_c[SQRT_IN_W-3:0], 2'b00};
				if (acc_c >= trial_c) begin
					rem_c = REM_W'(acc_c - trial_c);
					root_c = {root_c[ROOT_W-2:0], 1'b1};
				end else begin
					rem_c = REM_W'(acc_c);
					root_c = {root_c[ROOT_W-2:0], 1'b0};
				end
			end
			rad_n[g] = rad_c;
			rem_n[g] = rem_c;
			root_n[g] = root_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < SQRT_STAGES; g++) vld_s[g] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int g = 1; g < SQRT_STAGES; g++) vld_s[g] <= vld_s[g-1];
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < SQRT_STAGES; g++) begin
			rad_s[g] <= rad_n[g];
			rem_s[g] <= rem_n[g];
			root_s[g] <= root_n[g];
		end
	end

	always_comb begin
		active = 1'b0;
		for (int g = 0; g < SQRT_STAGES; g++) active = active | vld_s[g];
	end

	assign root_vld = vld_s[SQRT_STAGES-1];
	assign root = root_s[SQRT_STAGES-1];

endmodule

### rtl/core/bdc_cover.sv
// ---------------------------------------------------------------------------
// bdc_cover - coverage from distance
// Case select, small-dot product, pipelined restoring divide, clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdc_cover import bdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [ROOT_W-1:0] d12,
	input  bdc_cfg_t          cfg,
	output logic              done,
	output logic [COV_W-1:0]  coverage,
	output logic              active
);

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_FULL,
		KIND_DIV,
		KIND_DOT
	} kind_t;

	logic [ROOT_W:0] diff;
	kind_t kind;
	logic [NUM_W-1:0] num;

	logic vld_s1, vld_s2;
	kind_t kind_s1, kind_s2;
	logic [NUM_W-1:0] num_s1, num_s2;
	logic [COV_W-1:0] dot_s2;

	logic [DOT_P_W-1:0] prod;
	logic [DOT_P_W+COVER_FRAC_BITS-1:0] dot_wide;

	logic vld_d_s [DIV_STAGES];
	kind_t kind_d_s [DIV_STAGES];
	logic [NUM_W-1:0] rem_d_s [DIV_STAGES];
	logic [COVER_FRAC_BITS-1:0] quo_d_s [DIV_STAGES];
	logic [COV_W-1:0] dot_d_s [DIV_STAGES];

	logic [NUM_W-1:0] rem_n [DIV_STAGES];
	logic [COVER_FRAC_BITS-1:0] quo_n [DIV_STAGES];

	logic vld_out_s;
	logic [COV_W-1:0] cov_out_s;
	logic [COV_W-1:0] cov_sel;

	// case select
	always_comb begin
		diff = (ROOT_W+1)'(cfg.r12) - {1'b0, d12};
		if (cfg.dot_case) begin
			kind = (d12 < ONE_Q12) ? KIND_DOT : KIND_ZERO;
			num = NUM_W'(ONE_Q12 - d12);
		end else begin
			num = diff[NUM_W-1:0];
			if (diff[ROOT_W] || diff == '0)
				kind = KIND_ZERO;
			else if (diff >= (ROOT_W+1)'(cfg.den12))
				kind = KIND_FULL;
			else
				kind = KIND_DIV;
		end
	end

	// small dot: (1 - d) * radius
	always_comb begin
		prod = DOT_P_W'(num_s1[DOT_NUM_W-1:0]) * DOT_P_W'(cfg.r_dot);
		dot_wide = {prod, {COVER_FRAC_BITS{1'b0}}};
	end

	// restoring divide, one quotient bit per step
	always_comb begin
		logic [NUM_W-1:0] rem_c;
		logic [COVER_FRAC_BITS-1:0] quo_c;
		logic [NUM_W:0] t_c;
		for (int g = 0; g < DIV_STAGES; g++) begin
			if (g == 0) begin
				rem_c = num_s2;
				quo_c = '0;
			end else begin
				rem_c = rem_d_s[g-1];
				quo_c = quo_d_s[g-1];
			end
			for (int k = 0; k < DIV_STEPS; k++) begin
				t_c = {rem_c, 1'b0};
				if (g * DIV_STEPS + k < COVER_FRAC_BITS) begin
					if (t_c >= {1'b0, cfg.den12}) begin
						rem_c = NUM_W'(t_c - {1'b0, cfg.den12});
						quo_c = {quo_c[COVER_FRAC_BITS-2:0], 1'b1};
					end else begin
						rem_c = t_c[NUM_W-1:0];
						quo_c = {quo_c[COVER_FRAC_BITS-2:0], 1'b0};
					end
				end
			end
			rem_n[g] = rem_c;
			quo_n[g] = quo_c;
		end
	end

	always_comb begin
		case (kind_d_s[DIV_STAGES-1])
			KIND_ZERO: cov_sel = '0;
			KIND_FULL: cov_sel = COV_FULL;
			KIND_DIV:  cov_sel = {1'b0, quo_d_s[DIV_STAGES-1]};
			KIND_DOT:  cov_sel = dot_d_s[DIV_STAGES-1];
			default:   cov_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int g = 0; g < DIV_STAGES; g++) vld_d_s[g] <= 1'b0;
			vld_out_s <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_d_s[0] <= vld_s2;
			for (int g = 1; g < DIV_STAGES; g++) vld_d_s[g] <= vld_d_s[g-1];
			vld_out_s <= vld_d_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= kind;
		num_s1 <= num;
		kind_s2 <= kind_s1;
		num_s2 <= num_s1;
		dot_s2 <= dot_wide[DOT_SHIFT +: COV_W];
		kind_d_s[0] <= kind_s2;
		dot_d_s[0] <= dot_s2;
		for (int g = 1; g < DIV_STAGES; g++) begin
			kind_d_s[g] <= kind_d_s[g-1];
			dot_d_s[g] <= dot_d_s[g-1];
		end
		for (int g = 0; g < DIV_STAGES; g++) begin
			rem_d_s[g] <= rem_n[g];
			quo_d_s[g] <= quo_n[g];
		end
		cov_out_s <= cov_sel;
	end

	always_comb begin
		active = vld_s1 | vld_s2 | vld_out_s;
		for (int g = 0; g < DIV_STAGES; g++) active = active | vld_d_s[g];
	end

	assign done = vld_out_s;
	assign coverage = cov_out_s;

endmodule

### rtl/core/brush_dab_coverage_top.sv
// ---------------------------------------------------------------------------
// brush_dab_coverage_top - anti-aliased round dab coverage
// One pixel per clock; done follows start through the distance, square-root,
// select/dot, divide and output pipeline registers.
// busy stays low; reset clears all valid bits and loads register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "brush_dab_coverage_top_defines.svh"

module brush_dab_coverage_top import bdc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [PIX_W-1:0] pixel_x,
	input  logic signed [PIX_W-1:0] pixel_y,
	output logic                    done,
	output logic [COV_W-1:0]        coverage,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data
);

	logic signed [CTR_W-1:0] center_x_q;
	logic signed [CTR_W-1:0] center_y_q;
	logic [RAD_W-1:0] radius_q;
	logic [EDGE_W-1:0] edge_q;
	bdc_cfg_t cfg_d_q;

	logic cfg_we;
	logic sq_vld;
	logic [SQ_W-1:0] sq;
	logic root_vld;
	logic [ROOT_W-1:0] root;
	logic dist_active, sqrt_active, cover_active;

	assign busy = 1'b0;
	assign cfg_ready = !(start | dist_active | sqrt_active | cover_active);
	assign cfg_we = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q <= RADIUS_RST;
			edge_q <= EDGE_RST;
			cfg_d_q <= derive_cfg(RADIUS_RST, EDGE_RST);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CENTER_X:   center_x_q <= cfg_data[CTR_W-1:0];
					REG_CENTER_Y:   center_y_q <= cfg_data[CTR_W-1:0];
					REG_DAB_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
					REG_EDGE_WIDTH: edge_q <= cfg_data[EDGE_W-1:0];
					default:        ;
				endcase
			end
			cfg_d_q <= derive_cfg(radius_q, edge_q);
		end
	end

	bdc_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.sq_vld   (sq_vld),
		.sq       (sq),
		.active   (dist_active)
	);

	bdc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (sq_vld),
		.sq       (sq),
		.root_vld (root_vld),
		.root     (root),
		.active   (sqrt_active)
	);

	bdc_cover u_cover (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (root_vld),
		.d12      (root),
		.cfg      (cfg_d_q),
		.done     (done),
		.coverage (coverage),
		.active   (cover_active)
	);

	`BDC_ASSERT_DLY(a_start_done, start, LATENCY, done, "accepted pixel produced no result")
	`BDC_ASSERT_IMP(a_done_src, done, $past(start, LATENCY), "result without a pixel")
	`BDC_ASSERT_IMP(a_cov_max, done, coverage <= COV_FULL, "coverage above full")
	`BDC_ASSERT_NXT(a_cfg_hold, start, !cfg_ready, "config open with pixels in flight")
	`BDC_ASSERT_IMP(a_zero_rad, done && radius_q == '0, coverage == '0, "zero radius covers")

endmodule
